@@ design/aet_pkg.sv @@
package aet_pkg;

	typedef enum logic [1:0] {
		ST_ALLOC_STORED = 2'd0,
		ST_ALLOC_FULL   = 2'd1,
		ST_FREE_MATCHED = 2'd2,
		ST_FREE_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	localparam int USAGE_BITS = 48;
	localparam int COUNT_BITS = 32;
	localparam int LIVE_BITS  = 9;
	localparam int FREED_BITS = 32;

endpackage

@@ design/aet_if.sv @@
interface aet_in_if #(
	parameter int ADDR_BITS = 48,
	parameter int SIZE_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [ADDR_BITS-1:0] block_address;
	logic [SIZE_BITS-1:0] alloc_size;

	modport source (output valid, operation, block_address, alloc_size, input ready);
	modport sink (input valid, operation, block_address, alloc_size, output ready);
endinterface

interface aet_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] freed_size;
	logic [47:0] current_usage;
	logic [47:0] peak_usage;
	logic [31:0] alloc_total;
	logic [31:0] free_total;
	logic [8:0]  live_count;

	modport source (output valid, status, freed_size, current_usage, peak_usage,
		alloc_total, free_total, live_count, input ready);
	modport sink (input valid, status, freed_size, current_usage, peak_usage,
		alloc_total, free_total, live_count, output ready);
endinterface

@@ design/allocation_event_tracker_top.sv @@
// channel  | dir | handshake    | payload
// in_ch    | in  | valid/ready  | operation, block_address, alloc_size
// out_ch   | out | valid/ready  | status, freed_size, usage, peak, totals, live_count
//
// Allocation: the back sequencer pops a beat, writes the table and reports from S_DONE. Free:
// each entry scanned passes S_RD then S_CMP up to the match, then each entry shifted down passes
// S_SHIFT_RD then S_SHIFT_WR; the table has one write and one registered read port.
// Reset clears counters, usage and queue pointers; table contents need none.
// A two-entry queue takes input beats while the back end works or the output stalls.
module allocation_event_tracker_top import aet_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int ADDR_BITS = 48,
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	aet_in_if.sink     in_ch,
	aet_out_if.source  out_ch
);

	logic                 pop, q_valid, q_operation;
	logic [ADDR_BITS-1:0] q_address;
	logic [SIZE_BITS-1:0] q_size;

	aet_front #(.ADDR_BITS(ADDR_BITS), .SIZE_BITS(SIZE_BITS), .QUEUE_DEPTH(2)) u_front (
		.clk, .arst_n, .in_ch, .pop, .q_valid, .q_operation, .q_address, .q_size
	);

	aet_back #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_BITS(ADDR_BITS), .SIZE_BITS(SIZE_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_operation, .q_address, .q_size, .pop, .out_ch
	);

endmodule

@@ design/aet_front.sv @@
module aet_front import aet_pkg::*; #(
	parameter int ADDR_BITS = 48,
	parameter int SIZE_BITS = 32,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	aet_in_if.sink               in_ch,
	input  logic                 pop,
	output logic                 q_valid,
	output logic                 q_operation,
	output logic [ADDR_BITS-1:0] q_address,
	output logic [SIZE_BITS-1:0] q_size
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	logic [ADDR_BITS-1:0] addr_mem [QUEUE_DEPTH];
	logic [SIZE_BITS-1:0] size_mem [QUEUE_DEPTH];
	logic                 op_mem   [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]    fill_q;
	logic                 push;

	assign in_ch.ready = (fill_q != (PTR_BITS+1)'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (fill_q != '0);
	assign q_operation = op_mem[rd_ptr_q];
	assign q_address   = addr_mem[rd_ptr_q];
	// free beats carry a zero size into the queue
	assign q_size      = size_mem[rd_ptr_q];

	// store accepted beat
	always_ff @(posedge clk) begin
		if (push) begin
			op_mem[wr_ptr_q]   <= in_ch.operation;
			addr_mem[wr_ptr_q] <= in_ch.block_address;
			size_mem[wr_ptr_q] <= (in_ch.operation == OP_FREE) ? '0 : in_ch.alloc_size;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop && q_valid)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			fill_q <= fill_q + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop && q_valid);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (PTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue overfill");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("fill count slip");

endmodule

@@ design/aet_back.sv @@
module aet_back import aet_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int ADDR_BITS = 48,
	parameter int SIZE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic                 q_operation,
	input  logic [ADDR_BITS-1:0] q_address,
	input  logic [SIZE_BITS-1:0] q_size,
	output logic                 pop,
	aet_out_if.source            out_ch
);

	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
	localparam logic [USAGE_BITS-1:0] USAGE_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_DONE
	} state_t;

	// table memories: one write, one registered read
	logic [ADDR_BITS-1:0] addr_ram [TABLE_DEPTH];
	logic [SIZE_BITS-1:0] size_ram [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] rd_addr_q;
	logic [SIZE_BITS-1:0] rd_size_q;
	logic [IDX_BITS-1:0]  rd_idx;
	logic                 wr_en;
	logic [IDX_BITS-1:0]  wr_idx;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [SIZE_BITS-1:0] wr_size;

	state_t               state_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  idx_q;
	logic                 op_q;
	logic [ADDR_BITS-1:0] key_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [USAGE_BITS-1:0] usage_q, peak_q;
	logic [COUNT_BITS-1:0] allocs_q, frees_q;
	logic [1:0]            status_q;
	logic [SIZE_BITS-1:0]  freed_q;
	logic                  out_valid_q;
	logic [USAGE_BITS:0]   usage_sum;
	logic [USAGE_BITS-1:0] freed_ext;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_ram[wr_idx] <= wr_addr;
			size_ram[wr_idx] <= wr_size;
		end
		rd_addr_q <= addr_ram[rd_idx];
		rd_size_q <= size_ram[rd_idx];
	end

	assign usage_sum = {1'b0, usage_q} + (USAGE_BITS+1)'(size_q);
	assign freed_ext = USAGE_BITS'(rd_size_q);
	assign pop = (state_q == S_IDLE) && q_valid && !out_valid_q;

	// memory port steering
	always_comb begin
		rd_idx  = idx_q[IDX_BITS-1:0];
		wr_en   = 1'b0;
		wr_idx  = idx_q[IDX_BITS-1:0];
		wr_addr = rd_addr_q;
		wr_size = rd_size_q;
		case (state_q)
			S_IDLE: begin
				wr_en   = pop && (q_operation == OP_ALLOC) &&
				          (count_q != CNT_BITS'(TABLE_DEPTH));
				wr_idx  = count_q[IDX_BITS-1:0];
				wr_addr = q_address;
				wr_size = q_size;
			end
			S_SHIFT_RD: rd_idx = IDX_BITS'(idx_q + 1'b1);
			S_SHIFT_WR: wr_en = 1'b1;
			default: ;
		endcase
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.freed_size    = FREED_BITS'(freed_q);
	assign out_ch.current_usage = usage_q;
	assign out_ch.peak_usage    = peak_q;
	assign out_ch.alloc_total   = allocs_q;
	assign out_ch.free_total    = frees_q;
	assign out_ch.live_count    = LIVE_BITS'(count_q);

	// sequencer: append, scan, shift down, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			op_q        <= 1'b0;
			key_q       <= '0;
			size_q      <= '0;
			usage_q     <= '0;
			peak_q      <= '0;
			allocs_q    <= '0;
			frees_q     <= '0;
			status_q    <= ST_ALLOC_STORED;
			freed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						op_q   <= q_operation;
						key_q  <= q_address;
						size_q <= q_size;
						idx_q  <= '0;
						freed_q <= '0;
						if (q_operation == OP_ALLOC) begin
							if (count_q != CNT_BITS'(TABLE_DEPTH)) begin
								count_q  <= count_q + 1'b1;
								status_q <= ST_ALLOC_STORED;
							end else begin
								status_q <= ST_ALLOC_FULL;
							end
							if (allocs_q != COUNT_MAX)
								allocs_q <= allocs_q + 1'b1;
							state_q <= S_DONE;
						end else begin
							status_q <= ST_FREE_UNKNOWN;
							state_q  <= (count_q == '0) ? S_DONE : S_RD;
						end
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (rd_addr_q == key_q) begin
						freed_q  <= rd_size_q;
						status_q <= ST_FREE_MATCHED;
						usage_q  <= (freed_ext > usage_q) ? '0 : usage_q - freed_ext;
						if (frees_q != COUNT_MAX)
							frees_q <= frees_q + 1'b1;
						state_q <= (idx_q + 1'b1 < count_q) ? S_SHIFT_RD : S_DONE;
						if (!(idx_q + 1'b1 < count_q))
							count_q <= count_q - 1'b1;
					end else if (idx_q + 1'b1 < count_q) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q + 2'd2 < count_q) begin
						state_q <= S_SHIFT_RD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (op_q == OP_ALLOC) begin
						usage_q <= usage_sum[USAGE_BITS] ? USAGE_MAX : usage_sum[USAGE_BITS-1:0];
						if ((usage_sum[USAGE_BITS] ? USAGE_MAX : usage_sum[USAGE_BITS-1:0]) > peak_q)
							peak_q <= usage_sum[USAGE_BITS] ? USAGE_MAX
							        : usage_sum[USAGE_BITS-1:0];
					end
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(TABLE_DEPTH))
		else $error("live count beyond table");
	a_peak_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> peak_q >= usage_q)
		else $error("peak below usage");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != S_IDLE)
		else $error("popped beat not started");

endmodule

@@ verif/aet_tb_if.sv @@
`timescale 1ns / 1ps

// Interfaces come from the design file; this file holds testbench-side shared types.
package aet_tb_pkg;
	import aet_pkg::*;

	// One event beat offered to the tracker
	typedef struct {
		op_t         op;
		logic [47:0] addr;
		logic [31:0] size;
	} event_beat_t;

	// One result beat
	typedef struct packed {
		status_t     status;
		logic [31:0] freed_size;
		logic [47:0] current_usage;
		logic [47:0] peak_usage;
		logic [31:0] alloc_total;
		logic [31:0] free_total;
		logic [8:0]  live_count;
	} usage_report_t;
endpackage

@@ verif/allocation_event_tracker_top_tb.sv @@
`timescale 1ns / 1ps

module allocation_event_tracker_top_tb;
	import aet_pkg::*;
	import aet_tb_pkg::*;

	localparam int DEPTH = 256;
	localparam logic [47:0] USAGE_SAT = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF;
	localparam int RANDOM_EVENTS = 930;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aet_in_if #(.ADDR_BITS(48), .SIZE_BITS(32)) in_ch ();
	aet_out_if out_ch ();

	allocation_event_tracker_top #(.TABLE_DEPTH(DEPTH), .ADDR_BITS(48), .SIZE_BITS(32)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// Shadow tracker state
	logic [47:0] live_addr [DEPTH];
	logic [31:0] live_size [DEPTH];
	int          live_n;
	logic [47:0] usage_now;
	logic [47:0] usage_peak;
	logic [31:0] allocs_seen;
	logic [31:0] frees_seen;

	usage_report_t expected_reports[$];
	event_beat_t   event_plan[$];
	bit            directed_known[$];
	usage_report_t directed_report[$];
	int            error_count = 0;
	int            idle_cycles = 0;
	bit            stimulus_done = 0;
	bit            hold_off_req = 0;

	// Compute the report for one event and advance the shadow table
	function automatic usage_report_t track_event(event_beat_t ev);
		usage_report_t r;
		logic [48:0] sum;
		r.freed_size = '0;
		if (ev.op == OP_ALLOC) begin
			if (live_n < DEPTH) begin
				live_addr[live_n] = ev.addr;
				live_size[live_n] = ev.size;
				live_n++;
				r.status = ST_ALLOC_STORED;
			end else begin
				r.status = ST_ALLOC_FULL;
			end
			sum = {1'b0, usage_now} + {17'b0, ev.size};
			usage_now = sum[48] ? USAGE_SAT : sum[47:0];
			if (usage_now > usage_peak) usage_peak = usage_now;
			if (allocs_seen != COUNT_SAT) allocs_seen++;
		end else begin
			r.status = ST_FREE_UNKNOWN;
			for (int i = 0; i < live_n; i++) begin
				if (live_addr[i] == ev.addr) begin
					r.freed_size = live_size[i];
					for (int j = i; j + 1 < live_n; j++) begin
						live_addr[j] = live_addr[j + 1];
						live_size[j] = live_size[j + 1];
					end
					live_n--;
					if ({16'b0, r.freed_size} > usage_now) usage_now = '0;
					else usage_now = usage_now - {16'b0, r.freed_size};
					if (frees_seen != COUNT_SAT) frees_seen++;
					r.status = ST_FREE_MATCHED;
					break;
				end
			end
		end
		r.current_usage = usage_now;
		r.peak_usage = usage_peak;
		r.alloc_total = allocs_seen;
		r.free_total = frees_seen;
		r.live_count = 9'(live_n);
		return r;
	endfunction

	function automatic event_beat_t mk(op_t op, logic [47:0] addr, logic [31:0] size);
		event_beat_t e;
		e.op = op;
		e.addr = addr;
		e.size = size;
		return e;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Directed rows; the expected report is typed in where it is obvious
	task automatic add_row(event_beat_t e, bit known, usage_report_t r);
		event_plan.push_back(e);
		directed_known.push_back(known);
		directed_report.push_back(r);
	endtask

	task automatic build_directed();
		usage_report_t r;
		usage_report_t none;
		none = '{ST_ALLOC_STORED, 0, 0, 0, 0, 0, 0};
		// unknown free straight after reset
		r = '{ST_FREE_UNKNOWN, 0, 0, 0, 0, 0, 0};
		add_row(mk(OP_FREE, 48'h0, 32'hFFFF_FFFF), 1, r);
		r = '{ST_ALLOC_STORED, 0, 48'h0, 48'h0, 1, 0, 1};
		add_row(mk(OP_ALLOC, 48'h0, 32'h0), 1, r);
		r = '{ST_ALLOC_STORED, 0, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 2, 0, 2};
		add_row(mk(OP_ALLOC, USAGE_SAT, COUNT_SAT), 1, r);
		// duplicate address: oldest goes first
		add_row(mk(OP_ALLOC, 48'h1234, 32'd10), 0, none);
		add_row(mk(OP_ALLOC, 48'h1234, 32'd20), 0, none);
		add_row(mk(OP_FREE, 48'h1234, 32'd0), 0, none);
		add_row(mk(OP_FREE, USAGE_SAT, 32'hAAAA_5555), 0, none);
		add_row(mk(OP_FREE, 48'h5555_AAAA_5555, 32'd0), 0, none);
		add_row(mk(OP_FREE, 48'h0, 32'd0), 0, none);
		// eight maximum-size allocations to drive usage up, then free them all
		for (int k = 0; k < 8; k++)
			add_row(mk(OP_ALLOC, 48'hF000 + k, COUNT_SAT), 0, none);
		for (int k = 0; k < 8; k++)
			add_row(mk(OP_FREE, 48'hF000 + k, 32'd0), 0, none);
		add_row(mk(OP_FREE, 48'h1234, 32'd0), 0, none);
	endtask

	// Random part: mostly allocs and frees of live addresses, one table fill burst
	task automatic build_random();
		logic [47:0] pool [$];
		int n;
		int idx;
		logic [47:0] a;
		n = 0;
		while (n < RANDOM_EVENTS) begin
			if (n == 300) begin
				// fill past the top to hit the full table, then drain
				for (int k = 0; k < DEPTH + 6; k++) begin
					a = {16'($urandom_range(0, 65535)), $urandom()};
					event_plan.push_back(mk(OP_ALLOC, a, $urandom_range(0, 4096)));
					pool.push_back(a);
				end
				n += DEPTH + 6;
				continue;
			end
			if ($urandom_range(0, 99) < 55 || pool.size() == 0) begin
				case ($urandom_range(0, 3))
					0: a = 48'(pool.size() != 0 ? pool[$urandom_range(0, pool.size() - 1)]
						: 48'h0);
					1: a = {16'($urandom_range(0, 65535)), $urandom()};
					default: a = 48'($urandom_range(0, 63));
				endcase
				event_plan.push_back(mk(OP_ALLOC, a,
					($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1 << 16)));
				pool.push_back(a);
			end else if ($urandom_range(0, 9) < 8) begin
				idx = $urandom_range(0, pool.size() - 1);
				event_plan.push_back(mk(OP_FREE, pool[idx], $urandom()));
				pool.delete(idx);
			end else begin
				event_plan.push_back(mk(OP_FREE, {16'($urandom_range(0, 65535)), $urandom()},
					$urandom()));
			end
			n++;
		end
	endtask

	// Source: present beats at the falling edge, predict on acceptance
	initial begin
		usage_report_t r;
		int gap;
		in_ch.valid = 1'b0;
		in_ch.operation = 1'b0;
		in_ch.block_address = '0;
		in_ch.alloc_size = '0;
		live_n = 0;
		usage_now = '0;
		usage_peak = '0;
		allocs_seen = '0;
		frees_seen = '0;
		build_directed();
		build_random();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int k = 0; k < event_plan.size(); k++) begin
			gap = (k > 200 && k < 260) ? 0 : gap_len();
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			if (k == 120) hold_off_req = 1;
			in_ch.valid <= 1'b1;
			in_ch.operation <= event_plan[k].op;
			in_ch.block_address <= event_plan[k].addr;
			in_ch.alloc_size <= event_plan[k].size;
			do @(posedge clk); while (!in_ch.ready);
			r = track_event(event_plan[k]);
			if (k < directed_known.size() && directed_known[k] && r != directed_report[k]) begin
				$error("directed row %0d: typed-in report disagrees with tracker", k);
				error_count++;
			end
			expected_reports.push_back(r);
			@(negedge clk);
		end
		in_ch.valid <= 1'b0;
		stimulus_done = 1;
	end

	// Sink: random stalls, one long hold-off while the source keeps pushing
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				out_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			gap = gap_len();
			if (gap != 0 && $urandom_range(0, 1)) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Compare each report against the oldest expectation
	always @(posedge clk) begin
		usage_report_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$error("report beat with nothing expected");
				error_count++;
			end else begin
				e = expected_reports.pop_front();
				if (out_ch.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, out_ch.status);
					error_count++;
				end
				if (out_ch.freed_size !== e.freed_size) begin
					$error("freed_size: expected %0h, got %0h", e.freed_size, out_ch.freed_size);
					error_count++;
				end
				if (out_ch.current_usage !== e.current_usage) begin
					$error("current_usage: expected %0h, got %0h", e.current_usage,
						out_ch.current_usage);
					error_count++;
				end
				if (out_ch.peak_usage !== e.peak_usage) begin
					$error("peak_usage: expected %0h, got %0h", e.peak_usage, out_ch.peak_usage);
					error_count++;
				end
				if (out_ch.alloc_total !== e.alloc_total) begin
					$error("alloc_total: expected %0d, got %0d", e.alloc_total, out_ch.alloc_total);
					error_count++;
				end
				if (out_ch.free_total !== e.free_total) begin
					$error("free_total: expected %0d, got %0d", e.free_total, out_ch.free_total);
					error_count++;
				end
				if (out_ch.live_count !== e.live_count) begin
					$error("live_count: expected %0d, got %0d", e.live_count, out_ch.live_count);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	// Finish once drained, or on a stall
	initial begin
		@(posedge arst_n);
		fork
			begin
				wait (stimulus_done && expected_reports.size() == 0);
				repeat (600) @(posedge clk);
			end
			wait (idle_cycles >= IDLE_LIMIT);
		join_any
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d reports outstanding", expected_reports.size());
			error_count++;
		end
		if (expected_reports.size() != 0) begin
			$error("%0d reports never arrived", expected_reports.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
